// File: hdl/nbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nbc_pkg;

    // Field widths fixed by the interface
    localparam int DIGIT_W = 5;
    localparam int RADIX_W = 6;

    typedef logic [DIGIT_W-1:0]        t_digit;
    typedef logic signed [RADIX_W-1:0] t_radix;

    // Legal radix window; values outside are clamped to the nearest end
    localparam t_radix RADIX_RESET = -6'sd2;
    localparam t_radix RADIX_TOP   = -6'sd2;
    localparam t_radix RADIX_FLOOR = -6'sd20;
    localparam t_digit BASE_MIN    = 5'd2;
    localparam t_digit BASE_MAX    = 5'd20;

    // Dividend bits retired per divider cycle
    localparam int DIV_STEP_BITS = 8;

endpackage

`default_nettype wire

// File: hdl/nbc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one signed value per beat
interface nbc_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one digit per beat, most significant first
interface nbc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] digit;
    logic       last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/nbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nbc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 34
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/negative_base_convert_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequence: each digit runs the divider over W bits (W = VALUE_BITS rounded up to a multiple
//   of 8) and then a fix-up state; each emitted digit passes the read, load and send states.
// Throughput: one value at a time; the input is ready only when the previous run has
//   delivered its last digit. The shared 8-bit-per-cycle restoring divider sets the pace.
// Reset: synchronous, active low; clears control state and sets the radix to -2.
//   The digit store needs no clearing.
module negative_base_convert_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 34
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire nbc_pkg::t_radix i_cfg_data,
    nbc_in_if.sink               i_in,
    nbc_out_if.source            o_out
);
    import nbc_pkg::*;

    localparam int MAG_W  = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int STEPS  = MAG_W / DIV_STEP_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_SEND = 3'd5;

    logic [2:0]        r_state, n_state;
    t_radix            r_radix;
    t_digit            r_base, n_base;
    logic              r_neg, n_neg;
    logic [MAG_W-1:0]  r_quo, n_quo;
    t_digit            r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    t_digit            r_out_digit, n_out_digit;
    logic              r_out_last, n_out_last;

    t_radix              w_neg_radix;
    t_digit              w_base;
    logic [VALUE_BITS:0] w_in_ext;
    logic [VALUE_BITS:0] w_in_abs;
    logic [MAG_W-1:0]    w_div_q;
    logic [DIGIT_W:0]    w_div_r;
    logic                w_fix_adj;
    t_digit              w_fix_digit;
    logic [MAG_W-1:0]    w_fix_mag;
    logic                w_ram_we;
    t_digit              w_ram_rdata;

    // Clamp the configured radix to a base magnitude of 2 to 20
    assign w_neg_radix = -r_radix;
    always_comb begin
        if (r_radix > RADIX_TOP) begin
            w_base = BASE_MIN;
        end else if (r_radix < RADIX_FLOOR) begin
            w_base = BASE_MAX;
        end else begin
            w_base = w_neg_radix[DIGIT_W-1:0];
        end
    end

    // Take the magnitude of the incoming value
    assign w_in_ext = {i_in.value[VALUE_BITS-1], i_in.value};
    assign w_in_abs = i_in.value[VALUE_BITS-1] ? (~w_in_ext + 1'b1) : w_in_ext;

    // Restoring divider: retire DIV_STEP_BITS dividend bits per cycle
    always_comb begin
        w_div_q = r_quo;
        w_div_r = {1'b0, r_rem};
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            w_div_r = {w_div_r[DIGIT_W-1:0], w_div_q[MAG_W-1]};
            w_div_q = {w_div_q[MAG_W-2:0], 1'b0};
            if (w_div_r >= {1'b0, r_base}) begin
                w_div_r    = w_div_r - {1'b0, r_base};
                w_div_q[0] = 1'b1;
            end
        end
    end

    // Floor correction: negative dividend with nonzero remainder
    assign w_fix_adj   = r_neg && (r_rem != '0);
    assign w_fix_digit = w_fix_adj ? (r_base - r_rem) : r_rem;
    assign w_fix_mag   = w_fix_adj ? (r_quo + MAG_W'(1)) : r_quo;
    assign w_ram_we    = (r_state == S_FIX);

    nbc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_fix_digit),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_neg       = r_neg;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_digit = r_out_digit;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_base  = w_base;
                    n_neg   = i_in.value[VALUE_BITS-1];
                    n_quo   = MAG_W'(w_in_abs[VALUE_BITS-1:0]);
                    n_rem   = '0;
                    n_step  = STEP_W'(STEPS - 1);
                    n_count = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo  = w_div_q;
                n_rem  = w_div_r[DIGIT_W-1:0];
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // Store the digit, negate the quotient for the next round
                n_count = r_count + 1'b1;
                n_quo   = w_fix_mag;
                n_rem   = '0;
                n_neg   = !r_neg;
                n_step  = STEP_W'(STEPS - 1);
                if ((w_fix_mag == '0) || (r_count == CNT_W'(MAX_DIGITS - 1))) begin
                    n_idx   = r_count[ADDR_W-1:0];
                    n_state = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_out_digit = w_ram_rdata;
                n_out_last  = (r_idx == '0);
                n_state     = S_SEND;
            end
            S_SEND: begin
                // Hold the beat until taken, then step down to the next digit or return to idle after the last
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_neg       <= n_neg;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_idx       <= n_idx;
        r_out_digit <= n_out_digit;
        r_out_last  <= n_out_last;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.digit = r_out_digit;
    assign o_out.last  = r_out_last;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a digit is pending");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.digit < r_base))
        else $error("digit not below base");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_FIX)) |-> (r_rem < r_base))
        else $error("divider remainder out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("not ready after final digit");

endmodule

`default_nettype wire
